/* rtl/fpiw_pkg.sv */
// Package for the factor product index walker: sizes, register map,
// configuration and result structs, shared helper functions.
// No dependencies.
package fpiw_pkg;

    localparam int MAX_DIMS   = 4;
    localparam int INDEX_BITS = 12;
    localparam int CARD_BITS  = 6;
    localparam int NDIM_BITS  = 3;

    // APB: 64-bit data, registers at 8-byte spacing
    localparam int DATA_BITS  = 64;
    localparam int ADDR_BITS  = 6;
    localparam int RIDX_BITS  = 3;

    typedef logic [RIDX_BITS-1:0] reg_idx_t;

    localparam reg_idx_t REG_NUM_DIMS      = 3'd0;
    localparam reg_idx_t REG_DIM_SIZES     = 3'd1;
    localparam reg_idx_t REG_STRIDES_A     = 3'd2;
    localparam reg_idx_t REG_STRIDES_B     = 3'd3;
    localparam reg_idx_t REG_ELIM_SIZE     = 3'd4;
    localparam reg_idx_t REG_ELIM_STRIDE_A = 3'd5;
    localparam reg_idx_t REG_ELIM_STRIDE_B = 3'd6;

    typedef logic [INDEX_BITS-1:0] index_t;
    typedef logic [CARD_BITS-1:0]  card_t;

    typedef struct packed {
        logic [NDIM_BITS-1:0]               num_dims;
        logic [MAX_DIMS*CARD_BITS-1:0]      dim_sizes;
        logic [MAX_DIMS*INDEX_BITS-1:0]     strides_a;
        logic [MAX_DIMS*INDEX_BITS-1:0]     strides_b;
        card_t                              elim_size;
        index_t                             elim_stride_a;
        index_t                             elim_stride_b;
    } cfg_t;

    // (size-1)*stride per digit, subtracted when that digit wraps
    typedef struct packed {
        logic [MAX_DIMS-1:0][INDEX_BITS-1:0] dim_a;
        logic [MAX_DIMS-1:0][INDEX_BITS-1:0] dim_b;
        index_t                              elim_a;
        index_t                              elim_b;
    } wrap_t;

    typedef struct packed {
        index_t index_a;
        index_t index_b;
        index_t index_result;
        logic   first_term;
        logic   entry_done;
        logic   walk_done;
    } res_t;

    // last count value of a digit; a size of zero acts as one
    function automatic card_t size_m1(input card_t card);
        return (card == '0) ? '0 : card - card_t'(1);
    endfunction

    function automatic card_t dim_size(input cfg_t cfg, input int d);
        return cfg.dim_sizes[d*CARD_BITS +: CARD_BITS];
    endfunction

    function automatic index_t dim_stride_a(input cfg_t cfg, input int d);
        return cfg.strides_a[d*INDEX_BITS +: INDEX_BITS];
    endfunction

    function automatic index_t dim_stride_b(input cfg_t cfg, input int d);
        return cfg.strides_b[d*INDEX_BITS +: INDEX_BITS];
    endfunction

endpackage

/* rtl/fpiw_cfg.sv */
// APB register file for the walker, plus registered wind-back products.
// Depends on fpiw_pkg.
module fpiw_cfg (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [fpiw_pkg::ADDR_BITS-1:0]      paddr,
    input  logic [fpiw_pkg::DATA_BITS-1:0]      pwdata,
    output logic [fpiw_pkg::DATA_BITS-1:0]      prdata,
    output logic                                pready,
    output fpiw_pkg::cfg_t                      cfg,
    output fpiw_pkg::wrap_t                     wrap
);

    localparam int PROD_BITS = fpiw_pkg::CARD_BITS + fpiw_pkg::INDEX_BITS;

    // elim_size = 1, all else zero; elim_size sits just above the two elim strides
    localparam fpiw_pkg::cfg_t CFG_RESET =
        fpiw_pkg::cfg_t'(1) << (2 * fpiw_pkg::INDEX_BITS);

    fpiw_pkg::cfg_t   cfg_reg;
    fpiw_pkg::wrap_t  wrap_reg;
    fpiw_pkg::wrap_t  wrap_next;
    fpiw_pkg::reg_idx_t ridx;
    logic             wr_en;

    assign pready = 1'b1;
    assign ridx   = paddr[fpiw_pkg::ADDR_BITS-1 -: fpiw_pkg::RIDX_BITS];
    assign wr_en  = psel && penable && pwrite && pready;
    assign cfg    = cfg_reg;
    assign wrap   = wrap_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= CFG_RESET;
        end
        else if (wr_en)
        begin
            case (ridx)
                fpiw_pkg::REG_NUM_DIMS:
                    cfg_reg.num_dims <= pwdata[fpiw_pkg::NDIM_BITS-1:0];
                fpiw_pkg::REG_DIM_SIZES:
                    cfg_reg.dim_sizes <=
                        pwdata[fpiw_pkg::MAX_DIMS*fpiw_pkg::CARD_BITS-1:0];
                fpiw_pkg::REG_STRIDES_A:
                    cfg_reg.strides_a <=
                        pwdata[fpiw_pkg::MAX_DIMS*fpiw_pkg::INDEX_BITS-1:0];
                fpiw_pkg::REG_STRIDES_B:
                    cfg_reg.strides_b <=
                        pwdata[fpiw_pkg::MAX_DIMS*fpiw_pkg::INDEX_BITS-1:0];
                fpiw_pkg::REG_ELIM_SIZE:
                    cfg_reg.elim_size <= pwdata[fpiw_pkg::CARD_BITS-1:0];
                fpiw_pkg::REG_ELIM_STRIDE_A:
                    cfg_reg.elim_stride_a <= pwdata[fpiw_pkg::INDEX_BITS-1:0];
                fpiw_pkg::REG_ELIM_STRIDE_B:
                    cfg_reg.elim_stride_b <= pwdata[fpiw_pkg::INDEX_BITS-1:0];
                default:
                    ;
            endcase
        end
    end

    always_comb
    begin
        case (ridx)
            fpiw_pkg::REG_NUM_DIMS:
                prdata = fpiw_pkg::DATA_BITS'(cfg_reg.num_dims);
            fpiw_pkg::REG_DIM_SIZES:
                prdata = fpiw_pkg::DATA_BITS'(cfg_reg.dim_sizes);
            fpiw_pkg::REG_STRIDES_A:
                prdata = fpiw_pkg::DATA_BITS'(cfg_reg.strides_a);
            fpiw_pkg::REG_STRIDES_B:
                prdata = fpiw_pkg::DATA_BITS'(cfg_reg.strides_b);
            fpiw_pkg::REG_ELIM_SIZE:
                prdata = fpiw_pkg::DATA_BITS'(cfg_reg.elim_size);
            fpiw_pkg::REG_ELIM_STRIDE_A:
                prdata = fpiw_pkg::DATA_BITS'(cfg_reg.elim_stride_a);
            fpiw_pkg::REG_ELIM_STRIDE_B:
                prdata = fpiw_pkg::DATA_BITS'(cfg_reg.elim_stride_b);
            default:
                prdata = '0;
        endcase
    end

    // one small multiplier per digit and factor, result registered
    always_comb
    begin
        logic [PROD_BITS-1:0] pa;
        logic [PROD_BITS-1:0] pb;
        logic [PROD_BITS-1:0] sm;
        for (int d = 0; d < fpiw_pkg::MAX_DIMS; d++)
        begin
            sm = PROD_BITS'(fpiw_pkg::size_m1(fpiw_pkg::dim_size(cfg_reg, d)));
            pa = sm * PROD_BITS'(fpiw_pkg::dim_stride_a(cfg_reg, d));
            pb = sm * PROD_BITS'(fpiw_pkg::dim_stride_b(cfg_reg, d));
            wrap_next.dim_a[d] = pa[fpiw_pkg::INDEX_BITS-1:0];
            wrap_next.dim_b[d] = pb[fpiw_pkg::INDEX_BITS-1:0];
        end
        sm = PROD_BITS'(fpiw_pkg::size_m1(cfg_reg.elim_size));
        pa = sm * PROD_BITS'(cfg_reg.elim_stride_a);
        pb = sm * PROD_BITS'(cfg_reg.elim_stride_b);
        wrap_next.elim_a = pa[fpiw_pkg::INDEX_BITS-1:0];
        wrap_next.elim_b = pb[fpiw_pkg::INDEX_BITS-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wrap_reg <= '0;
        end
        else
        begin
            wrap_reg <= wrap_next;
        end
    end

endmodule

/* rtl/fpiw_step.sv */
// Odometer state and combinational step: issues one term and advances
// the digit counters and A/B/result positions. Depends on fpiw_pkg.
module fpiw_step (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             step,
    input  logic             restart,
    input  fpiw_pkg::cfg_t   cfg,
    input  fpiw_pkg::wrap_t  wrap,
    output fpiw_pkg::res_t   res
);

    logic [fpiw_pkg::MAX_DIMS-1:0][fpiw_pkg::CARD_BITS-1:0] digit_reg, digit_next;
    fpiw_pkg::card_t  elim_reg, elim_next;
    fpiw_pkg::index_t pos_a_reg, pos_a_next;
    fpiw_pkg::index_t pos_b_reg, pos_b_next;
    fpiw_pkg::index_t pos_r_reg, pos_r_next;

    always_comb
    begin
        logic [fpiw_pkg::MAX_DIMS-1:0][fpiw_pkg::CARD_BITS-1:0] cur_digit;
        fpiw_pkg::card_t  cur_elim;
        fpiw_pkg::index_t cur_a;
        fpiw_pkg::index_t cur_b;
        fpiw_pkg::index_t cur_r;
        logic [fpiw_pkg::NDIM_BITS:0] nd;
        logic [fpiw_pkg::MAX_DIMS-1:0] dim_last;
        logic entry_last;
        logic walk_last;
        logic carry;

        carry = 1'b0;

        // restart clears the walk before this term is issued
        cur_digit = restart ? '0 : digit_reg;
        cur_elim  = restart ? '0 : elim_reg;
        cur_a     = restart ? '0 : pos_a_reg;
        cur_b     = restart ? '0 : pos_b_reg;
        cur_r     = restart ? '0 : pos_r_reg;

        nd = ({1'b0, cfg.num_dims} > (fpiw_pkg::NDIM_BITS+1)'(fpiw_pkg::MAX_DIMS))
           ? (fpiw_pkg::NDIM_BITS+1)'(fpiw_pkg::MAX_DIMS) : {1'b0, cfg.num_dims};

        entry_last = cur_elim >= fpiw_pkg::size_m1(cfg.elim_size);
        for (int d = 0; d < fpiw_pkg::MAX_DIMS; d++)
        begin
            dim_last[d] = (d >= int'(nd))
                || (cur_digit[d] >= fpiw_pkg::size_m1(fpiw_pkg::dim_size(cfg, d)));
        end
        walk_last = entry_last && (&dim_last);

        res.index_a      = cur_a;
        res.index_b      = cur_b;
        res.index_result = cur_r;
        res.first_term   = (cur_elim == '0);
        res.entry_done   = entry_last;
        res.walk_done    = walk_last;

        digit_next = cur_digit;
        elim_next  = cur_elim;
        pos_a_next = cur_a;
        pos_b_next = cur_b;
        pos_r_next = cur_r;

        if (walk_last)
        begin
            digit_next = '0;
            elim_next  = '0;
            pos_a_next = '0;
            pos_b_next = '0;
            pos_r_next = '0;
        end
        else if (!entry_last)
        begin
            elim_next  = cur_elim + fpiw_pkg::card_t'(1);
            pos_a_next = cur_a + cfg.elim_stride_a;
            pos_b_next = cur_b + cfg.elim_stride_b;
        end
        else
        begin
            // inner digit wraps; carry ripples through the kept digits
            elim_next  = '0;
            pos_a_next = cur_a - wrap.elim_a;
            pos_b_next = cur_b - wrap.elim_b;
            carry      = 1'b1;
            for (int d = 0; d < fpiw_pkg::MAX_DIMS; d++)
            begin
                if (carry && (d < int'(nd)))
                begin
                    if (dim_last[d])
                    begin
                        digit_next[d] = '0;
                        pos_a_next    = pos_a_next - wrap.dim_a[d];
                        pos_b_next    = pos_b_next - wrap.dim_b[d];
                    end
                    else
                    begin
                        digit_next[d] = cur_digit[d] + fpiw_pkg::card_t'(1);
                        pos_a_next    = pos_a_next + fpiw_pkg::dim_stride_a(cfg, d);
                        pos_b_next    = pos_b_next + fpiw_pkg::dim_stride_b(cfg, d);
                        carry         = 1'b0;
                    end
                end
            end
            pos_r_next = cur_r + fpiw_pkg::index_t'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            digit_reg <= '0;
            elim_reg  <= '0;
            pos_a_reg <= '0;
            pos_b_reg <= '0;
            pos_r_reg <= '0;
        end
        else if (step)
        begin
            digit_reg <= digit_next;
            elim_reg  <= elim_next;
            pos_a_reg <= pos_a_next;
            pos_b_reg <= pos_b_next;
            pos_r_reg <= pos_r_next;
        end
    end

endmodule

/* rtl/factor_product_index_walk_top.sv */
// Top level of the factor product index walker: input and result registers
// around the odometer step, APB configuration. Depends on fpiw_pkg,
// fpiw_cfg, fpiw_step.
//
//   channel   handshake             payload
//   input     in_valid / in_ready   restart
//   output    out_valid / out_ready index_a, index_b, index_result,
//                                   first_term, entry_done, walk_done
//   config    APB psel/penable      paddr[5:3] = register, pwdata 64 bits
//
// One item per cycle sustained while the output is not stalled; each item
// is one term. The input register loads at the accepting edge and the
// result register when the item fires, which a stalled output can hold off.
// The odometer carry and position update resolve combinationally in that step.
// Reset clears the walk state and sets elim_size to 1, all else to zero.
// A stalled output holds its result; the input stage keeps accepting while
// the result register is free or being drained.
module factor_product_index_walk_top (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic                                restart,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [fpiw_pkg::INDEX_BITS-1:0]     index_a,
    output logic [fpiw_pkg::INDEX_BITS-1:0]     index_b,
    output logic [fpiw_pkg::INDEX_BITS-1:0]     index_result,
    output logic                                first_term,
    output logic                                entry_done,
    output logic                                walk_done,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [fpiw_pkg::ADDR_BITS-1:0]      paddr,
    input  logic [fpiw_pkg::DATA_BITS-1:0]      pwdata,
    output logic [fpiw_pkg::DATA_BITS-1:0]      prdata,
    output logic                                pready
);

    fpiw_pkg::cfg_t  cfg;
    fpiw_pkg::wrap_t wrap;
    fpiw_pkg::res_t  res;
    fpiw_pkg::res_t  res_reg;

    logic in_valid_reg;
    logic restart_reg;
    logic out_valid_reg;
    logic fire;

    fpiw_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg),
        .wrap    (wrap)
    );

    fpiw_step u_step (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (fire),
        .restart (restart_reg),
        .cfg     (cfg),
        .wrap    (wrap),
        .res     (res)
    );

    assign fire     = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || fire;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (fire)
            begin
                in_valid_reg <= 1'b0;
            end

            if (fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            restart_reg <= restart;
        end
        if (fire)
        begin
            res_reg <= res;
        end
    end

    assign out_valid    = out_valid_reg;
    assign index_a      = res_reg.index_a;
    assign index_b      = res_reg.index_b;
    assign index_result = res_reg.index_result;
    assign first_term   = res_reg.first_term;
    assign entry_done   = res_reg.entry_done;
    assign walk_done    = res_reg.walk_done;

`ifndef ASSERT_OFF
    // a stepped item always lands in the result register
    a_fire_to_out: assert property (@(posedge clk) disable iff (!rst_n)
        fire |=> out_valid_reg)
        else $error("stepped item did not reach result register");

    // the final term of the walk always closes its sum
    a_walk_entry: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && walk_done) |-> entry_done)
        else $error("walk_done without entry_done");

    // with no summed-out variable every term is its own sum
    a_plain_product: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (cfg.elim_size == fpiw_pkg::card_t'(1))
            && $stable(cfg.elim_size)) |-> entry_done)
        else $error("plain product term not closing its entry");
`endif

endmodule

/* dv/factor_product_index_walk_top_test.sv */
// Self-checking testbench for factor_product_index_walk_top: random idling and
// back-pressure, APB setup, term-by-term prediction of the odometer walk.
// Depends on fpiw_pkg and the block's RTL.
`timescale 1ns / 100ps

module factor_product_index_walk_top_test;

    localparam int CYCLE_LIMIT = 1000000;
    localparam int MAX_IDLE    = 14;

    typedef logic [fpiw_pkg::DATA_BITS-1:0] word_t;

    logic                               clk = 1'b0;
    logic                               rst_n;
    logic                               in_valid;
    logic                               in_ready;
    logic                               restart;
    logic                               out_valid;
    logic                               out_ready;
    fpiw_pkg::index_t                   index_a;
    fpiw_pkg::index_t                   index_b;
    fpiw_pkg::index_t                   index_result;
    logic                               first_term;
    logic                               entry_done;
    logic                               walk_done;
    logic                               psel;
    logic                               penable;
    logic                               pwrite;
    logic [fpiw_pkg::ADDR_BITS-1:0]     paddr;
    word_t                              pwdata;
    word_t                              prdata;
    logic                               pready;

    // walk state and register copy of the predictor
    fpiw_pkg::cfg_t     cfg_m;
    fpiw_pkg::card_t    digit_cnt [fpiw_pkg::MAX_DIMS];
    fpiw_pkg::card_t    elim_cnt;
    fpiw_pkg::index_t   walk_pos_a;
    fpiw_pkg::index_t   walk_pos_b;
    fpiw_pkg::index_t   walk_pos_r;

    fpiw_pkg::res_t     term_q [$];
    int                 fail_cnt  = 0;
    int                 cycle_cnt = 0;
    bit                 idle_on   = 1'b1;
    int                 hold_len  = 0;

    factor_product_index_walk_top u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .restart      (restart),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .index_a      (index_a),
        .index_b      (index_b),
        .index_result (index_result),
        .first_term   (first_term),
        .entry_done   (entry_done),
        .walk_done    (walk_done),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    function automatic int unsigned card_of(input int d);
        fpiw_pkg::card_t s;
        s = cfg_m.dim_sizes[d*fpiw_pkg::CARD_BITS +: fpiw_pkg::CARD_BITS];
        return (s == '0) ? 1 : 32'(s);
    endfunction

    function automatic void clear_walk();
        for (int d = 0; d < fpiw_pkg::MAX_DIMS; d++)
            digit_cnt[d] = '0;
        elim_cnt   = '0;
        walk_pos_a = '0;
        walk_pos_b = '0;
        walk_pos_r = '0;
    endfunction

    // issues one term and advances the odometer
    function automatic fpiw_pkg::res_t next_term(input logic rs);
        int unsigned    nd;
        int unsigned    esz;
        int unsigned    sz;
        int unsigned    sa;
        int unsigned    sb;
        logic           e_last;
        logic           w_last;
        logic           carry;
        fpiw_pkg::res_t r;
        nd  = (cfg_m.num_dims > fpiw_pkg::MAX_DIMS) ? fpiw_pkg::MAX_DIMS
                                                    : 32'(cfg_m.num_dims);
        esz = (cfg_m.elim_size == '0) ? 1 : 32'(cfg_m.elim_size);
        if (rs)
            clear_walk();
        e_last = (elim_cnt >= esz - 1);
        w_last = e_last;
        for (int d = 0; d < fpiw_pkg::MAX_DIMS; d++)
            if (d < nd && digit_cnt[d] < card_of(d) - 1)
                w_last = 1'b0;
        r.index_a      = walk_pos_a;
        r.index_b      = walk_pos_b;
        r.index_result = walk_pos_r;
        r.first_term   = (elim_cnt == '0);
        r.entry_done   = e_last;
        r.walk_done    = w_last;
        if (w_last)
            clear_walk();
        else if (!e_last)
        begin
            elim_cnt   = fpiw_pkg::card_t'(elim_cnt + 1'b1);
            walk_pos_a = walk_pos_a + cfg_m.elim_stride_a;
            walk_pos_b = walk_pos_b + cfg_m.elim_stride_b;
        end
        else
        begin
            elim_cnt   = '0;
            walk_pos_a = walk_pos_a - fpiw_pkg::index_t'((esz - 1) * cfg_m.elim_stride_a);
            walk_pos_b = walk_pos_b - fpiw_pkg::index_t'((esz - 1) * cfg_m.elim_stride_b);
            carry = 1'b1;
            for (int d = 0; d < fpiw_pkg::MAX_DIMS; d++)
            begin
                if (carry && d < nd)
                begin
                    sz = card_of(d);
                    sa = 32'(cfg_m.strides_a[d*fpiw_pkg::INDEX_BITS +: fpiw_pkg::INDEX_BITS]);
                    sb = 32'(cfg_m.strides_b[d*fpiw_pkg::INDEX_BITS +: fpiw_pkg::INDEX_BITS]);
                    if (digit_cnt[d] >= sz - 1)
                    begin
                        digit_cnt[d] = '0;
                        walk_pos_a   = walk_pos_a - fpiw_pkg::index_t'((sz - 1) * sa);
                        walk_pos_b   = walk_pos_b - fpiw_pkg::index_t'((sz - 1) * sb);
                    end
                    else
                    begin
                        digit_cnt[d] = fpiw_pkg::card_t'(digit_cnt[d] + 1'b1);
                        walk_pos_a   = walk_pos_a + fpiw_pkg::index_t'(sa);
                        walk_pos_b   = walk_pos_b + fpiw_pkg::index_t'(sb);
                        carry        = 1'b0;
                    end
                end
            end
            walk_pos_r = walk_pos_r + 1'b1;
        end
        return r;
    endfunction

    task automatic check_field(input string name, input fpiw_pkg::index_t exp_v,
                               input fpiw_pkg::index_t act_v);
        if (act_v !== exp_v)
        begin
            $display("%0t: %s expected %0h actual %0h", $time, name, exp_v, act_v);
            fail_cnt++;
        end
    endtask

    // result checker
    always @(posedge clk)
    begin
        fpiw_pkg::res_t exp_t;
        if (rst_n && out_valid && out_ready)
        begin
            if (term_q.size() == 0)
            begin
                $display("%0t: unexpected term, expected none actual %0h/%0h/%0h",
                         $time, index_a, index_b, index_result);
                fail_cnt++;
            end
            else
            begin
                exp_t = term_q.pop_front();
                check_field("index_a", exp_t.index_a, index_a);
                check_field("index_b", exp_t.index_b, index_b);
                check_field("index_result", exp_t.index_result, index_result);
                check_field("first_term", fpiw_pkg::index_t'(exp_t.first_term),
                            fpiw_pkg::index_t'(first_term));
                check_field("entry_done", fpiw_pkg::index_t'(exp_t.entry_done),
                            fpiw_pkg::index_t'(entry_done));
                check_field("walk_done", fpiw_pkg::index_t'(exp_t.walk_done),
                            fpiw_pkg::index_t'(walk_done));
            end
        end
    end

    // receiver: random stalls, plus one long hold-off on request
    initial
    begin
        int stall;
        out_ready <= 1'b0;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            if (hold_len > 0)
            begin
                stall    = hold_len;
                hold_len = 0;
            end
            else
                stall = idle_on ? $urandom_range(0, MAX_IDLE) : 0;
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!out_valid);
        end
    end

    // in_valid stays high after acceptance until the next item or drain
    task automatic send_item(input logic rs);
        int gap;
        gap = idle_on ? $urandom_range(0, MAX_IDLE) : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        restart  <= rs;
        do @(posedge clk); while (!in_ready);
        term_q.push_back(next_term(rs));
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (term_q.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input fpiw_pkg::reg_idx_t idx, input word_t val);
        word_t readback;
        case (idx)
            fpiw_pkg::REG_NUM_DIMS:
                cfg_m.num_dims = val[fpiw_pkg::NDIM_BITS-1:0];
            fpiw_pkg::REG_DIM_SIZES:
                cfg_m.dim_sizes = val[fpiw_pkg::MAX_DIMS*fpiw_pkg::CARD_BITS-1:0];
            fpiw_pkg::REG_STRIDES_A:
                cfg_m.strides_a = val[fpiw_pkg::MAX_DIMS*fpiw_pkg::INDEX_BITS-1:0];
            fpiw_pkg::REG_STRIDES_B:
                cfg_m.strides_b = val[fpiw_pkg::MAX_DIMS*fpiw_pkg::INDEX_BITS-1:0];
            fpiw_pkg::REG_ELIM_SIZE:
                cfg_m.elim_size = val[fpiw_pkg::CARD_BITS-1:0];
            fpiw_pkg::REG_ELIM_STRIDE_A:
                cfg_m.elim_stride_a = val[fpiw_pkg::INDEX_BITS-1:0];
            fpiw_pkg::REG_ELIM_STRIDE_B:
                cfg_m.elim_stride_b = val[fpiw_pkg::INDEX_BITS-1:0];
            default: ;
        endcase
        case (idx)
            fpiw_pkg::REG_NUM_DIMS:      readback = word_t'(cfg_m.num_dims);
            fpiw_pkg::REG_DIM_SIZES:     readback = word_t'(cfg_m.dim_sizes);
            fpiw_pkg::REG_STRIDES_A:     readback = word_t'(cfg_m.strides_a);
            fpiw_pkg::REG_STRIDES_B:     readback = word_t'(cfg_m.strides_b);
            fpiw_pkg::REG_ELIM_SIZE:     readback = word_t'(cfg_m.elim_size);
            fpiw_pkg::REG_ELIM_STRIDE_A: readback = word_t'(cfg_m.elim_stride_a);
            default:                     readback = word_t'(cfg_m.elim_stride_b);
        endcase
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        // read back the same register
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        if (prdata !== readback)
        begin
            $display("%0t: register %0d expected %0h actual %0h",
                     $time, idx, readback, prdata);
            fail_cnt++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic write_all(input word_t nd, input word_t sizes,
                             input word_t sa, input word_t sb,
                             input word_t es, input word_t esa,
                             input word_t esb);
        write_reg(fpiw_pkg::REG_NUM_DIMS, nd);
        write_reg(fpiw_pkg::REG_DIM_SIZES, sizes);
        write_reg(fpiw_pkg::REG_STRIDES_A, sa);
        write_reg(fpiw_pkg::REG_STRIDES_B, sb);
        write_reg(fpiw_pkg::REG_ELIM_SIZE, es);
        write_reg(fpiw_pkg::REG_ELIM_STRIDE_A, esa);
        write_reg(fpiw_pkg::REG_ELIM_STRIDE_B, esb);
    endtask

    // out of reset every term is a whole one-term walk at index zero
    task automatic test_reset_defaults();
        send_item(1'b0);
        send_item(1'b1);
        send_item(1'b0);
        drain();
    endtask

    // 3 x 2 kept digits, eliminated size 2: one full walk of 12 terms
    task automatic test_basic_walk();
        write_all(word_t'(2), word_t'((2 << 6) | 3), word_t'((3 << 12) | 1),
                  word_t'(1 << 12), word_t'(2), word_t'(9), word_t'(4));
        send_item(1'b1);
        repeat (11) send_item(1'b0);
        drain();
    endtask

    // zero sizes act as one, num_dims above the max acts as the max
    task automatic test_degenerate();
        write_all(word_t'(7), word_t'(0), word_t'({48{1'b1}}), word_t'({48{1'b1}}),
                  word_t'(0), word_t'(12'hfff), word_t'(12'hfff));
        send_item(1'b0);
        send_item(1'b1);
        drain();
    endtask

    // shrink a digit below its current count mid-walk
    task automatic test_count_past_size();
        write_all(word_t'(1), word_t'(6), word_t'(12'hfff), word_t'(12'h801),
                  word_t'(1), word_t'(0), word_t'(0));
        send_item(1'b1);
        repeat (3) send_item(1'b0);
        drain();
        write_reg(fpiw_pkg::REG_DIM_SIZES, word_t'(2));
        send_item(1'b0);
        send_item(1'b0);
        drain();
    endtask

    task automatic random_config(input int flavor);
        word_t sizes;
        int nd;
        int es;
        if (flavor == 1)
            write_all(word_t'(7), word_t'({24{1'b1}}), word_t'({48{1'b1}}),
                      word_t'({48{1'b1}}), word_t'(63), word_t'(12'hfff), word_t'(12'hfff));
        else if (flavor == 2)
            write_all(word_t'(0), word_t'(0), word_t'(0), word_t'(0),
                      word_t'(0), word_t'(0), word_t'(0));
        else
        begin
            nd = ($urandom_range(0, 7) == 0) ? $urandom_range(5, 7) : $urandom_range(0, 4);
            sizes = '0;
            for (int d = 0; d < fpiw_pkg::MAX_DIMS; d++)
                sizes[d*fpiw_pkg::CARD_BITS +: fpiw_pkg::CARD_BITS] =
                    fpiw_pkg::card_t'(($urandom_range(0, 9) == 0) ?
                        $urandom_range(0, 63) : $urandom_range(0, 4));
            es = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 63) : $urandom_range(0, 4);
            write_all(word_t'(nd), sizes, {$urandom, $urandom}, {$urandom, $urandom},
                      word_t'(es), word_t'($urandom), word_t'($urandom));
        end
    endtask

    // phases of random terms; a phase may start mid-walk without restart
    task automatic test_random_walks();
        for (int phase = 0; phase < 16; phase++)
        begin
            idle_on = (phase % 4 != 1);
            random_config((phase == 3) ? 1 : (phase == 7) ? 2 : 0);
            for (int i = 0; i < 95; i++)
                send_item((i == 0 && $urandom_range(0, 1)) || $urandom_range(0, 31) == 0);
            drain();
        end
        idle_on = 1'b1;
    endtask

    // long receiver hold-off while the sender keeps offering
    task automatic test_backpressure();
        random_config(0);
        idle_on  = 1'b0;
        hold_len = 300;
        send_item(1'b1);
        repeat (60) send_item(1'b0);
        drain();
        idle_on = 1'b1;
    endtask

    initial
    begin
        rst_n    <= 1'b0;
        in_valid <= 1'b0;
        restart  <= 1'b0;
        psel     <= 1'b0;
        penable  <= 1'b0;
        pwrite   <= 1'b0;
        paddr    <= '0;
        pwdata   <= '0;
        cfg_m            = '0;
        cfg_m.elim_size  = fpiw_pkg::card_t'(1);
        clear_walk();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_defaults();
        test_basic_walk();
        test_degenerate();
        test_count_past_size();
        test_random_walks();
        test_backpressure();

        drain();
        repeat (10) @(posedge clk);
        if (fail_cnt == 0 && term_q.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
